FILE: rtl/ttbc_pkg.sv
// Package for the tap-tempo beat clock: payload structs, controller states,
// register indexes and shared arithmetic constants. No dependencies.
package ttbc_pkg;

  typedef struct packed {
    logic        mode;
    logic [31:0] time_ms;
    logic [31:0] beat_bar;
  } ttbc_in_t;

  typedef struct packed {
    logic        event_valid;
    logic [31:0] event_bar;
    logic [31:0] tempo;
    logic        tempo_valid;
    logic [31:0] speed_out;
  } ttbc_out_t;

  localparam logic [1:0] CFG_EVENT_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_LIMIT_ENABLE   = 2'd1;
  localparam logic [1:0] CFG_LIMIT_BAR      = 2'd2;

  localparam logic [31:0] EVENT_INTERVAL_RST = 32'd65536;
  localparam logic [63:0] TEMPO_NUM          = 64'd60000 << 40;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_B_RD,
    ST_B_CHK,
    ST_IV_RD0,
    ST_IV_LD,
    ST_IV_RD,
    ST_IV_CMP,
    ST_PR_RD0,
    ST_PR_LD,
    ST_PR_RD,
    ST_PR_CMP,
    ST_PR_DIV,
    ST_SP,
    ST_SP_DIV,
    ST_TP,
    ST_TP_MUL,
    ST_TP_DIVS,
    ST_TP_DIV,
    ST_T_CHK,
    ST_T_RD,
    ST_T_DS,
    ST_T_DIV,
    ST_T_Q1S,
    ST_T_Q1,
    ST_T_Q2S,
    ST_T_Q2,
    ST_T_UPD,
    ST_DONE
  } ttbc_state_e;

  function automatic logic [31:0] sat32(logic [63:0] v);
    return (v[63:32] != 32'd0) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

endpackage

FILE: rtl/tap_tempo_beat_clock.sv
// Tap-tempo beat clock: beat history ring, speed and tempo estimation, event ticks.
// Depends on ttbc_pkg and ttbc_div.
//
// Usage: one transaction on the input channel (in_valid_i/in_ready_o) yields
// exactly one transaction on the output channel (out_valid_o/out_ready_i).
// mode 1 records a tapped beat and answers the tempo; mode 0 is a time tick
// that may answer an event bar. Config writes (cfg_valid_i/cfg_ready_o) are
// always taken and should happen while the block is idle.
// A tick does no division before the first beat or with zero speed; else it
// divides the elapsed time by the speed and, when it checks for an event
// crossing, divides both positions by the event interval. A beat walks the
// history with one division per rising pair, then takes the speed mean and the
// tempo; a repeated or first beat skips the walk and only computes the tempo when
// one is defined. Every division goes through one shared 64-bit bit-serial
// divider, and the tempo product through a shift-add multiplier.
// One item is processed at a time. The result register frees the input side:
// a new item is taken while the last result still waits, and the block only
// stalls at the end of the next item if the receiver has not taken it.
// Reset clears history count, speed, interval and tick state, and loads the
// config registers with their defaults.
module tap_tempo_beat_clock
  import ttbc_pkg::*;
#(
  parameter int BEAT_HISTORY = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  ttbc_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output ttbc_out_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int CW = $clog2(BEAT_HISTORY + 1);
  localparam int HW = $clog2(BEAT_HISTORY);

  ttbc_state_e state_q, state_d;

  logic [31:0]   ev_int_q, lim_bar_q;
  logic          lim_en_q;
  logic [CW-1:0] count_q, cnt_new, idx_q, n_q;
  logic [HW-1:0] head_q, head_next, rd_addr, newest;
  logic [31:0]   speed_q, interval_q, last_q;
  logic          iv_ok_q, lvalid_q;
  logic [31:0]   bars_q  [BEAT_HISTORY];
  logic [31:0]   times_q [BEAT_HISTORY];
  logic [31:0]   rd_bar_q, rd_time_q, prev_bar_q, prev_time_q;
  logic [63:0]   sum_q, mul_acc_q, mul_a_q;
  logic [31:0]   mul_b_q, pos_q, fb_q, lb;
  logic [4:0]    mul_cnt_q;
  ttbc_in_t      in_q;
  ttbc_out_t     res_q, out_q;
  logic          out_valid_q;
  logic          dup, pair_ok, go, ev_hit;
  logic [31:0]   tick_dt;
  logic          div_start, div_done;
  logic [63:0]   div_a, div_b, div_quot, div_rem;

  function automatic logic [HW-1:0] slot_of(logic [CW-1:0] k, logic [HW-1:0] h,
                                            logic [CW-1:0] c);
    logic [CW+1:0] t;
    t = (CW+2)'(h) + (CW+2)'(BEAT_HISTORY) - (CW+2)'(c) + (CW+2)'(k);
    if (t >= (CW+2)'(BEAT_HISTORY)) t = t - (CW+2)'(BEAT_HISTORY);
    if (t >= (CW+2)'(BEAT_HISTORY)) t = t - (CW+2)'(BEAT_HISTORY);
    return t[HW-1:0];
  endfunction

  ttbc_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_a),
    .divisor_i (div_b),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  assign newest    = slot_of(count_q - CW'(1), head_q, count_q);
  assign cnt_new   = ((count_q >= CW'(BEAT_HISTORY)) ? CW'(BEAT_HISTORY - 1) : count_q)
                     + CW'(1);
  assign head_next = (head_q == HW'(BEAT_HISTORY - 1)) ? '0 : head_q + HW'(1);
  assign dup       = (count_q != '0) && (rd_bar_q == in_q.beat_bar);
  assign pair_ok   = (rd_bar_q > prev_bar_q) && (rd_time_q > prev_time_q);
  assign go        = !out_valid_q || out_ready_i;
  assign tick_dt   = (in_q.time_ms > rd_time_q) ? in_q.time_ms - rd_time_q : 32'd0;
  assign lb        = last_q - div_rem[31:0];
  assign ev_hit    = (fb_q != lb) && (!lim_en_q || (fb_q < lim_bar_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    rd_addr   = newest;
    div_start = 1'b0;
    div_a     = '0;
    div_b     = '0;
    unique case (state_q)
      ST_IDLE:    if (in_valid_i) state_d = in_data_i.mode ? ST_B_RD : ST_T_CHK;
      ST_B_RD:    state_d = ST_B_CHK;
      ST_B_CHK: begin
        if (dup || (cnt_new < CW'(2))) state_d = ST_TP;
        else state_d = ST_IV_RD0;
      end
      ST_IV_RD0:  state_d = ST_IV_LD;
      ST_IV_LD:   state_d = ST_IV_RD;
      ST_IV_RD: begin
        rd_addr = slot_of(idx_q - CW'(1), head_q, count_q);
        state_d = ST_IV_CMP;
      end
      ST_IV_CMP: begin
        if (prev_bar_q > rd_bar_q) state_d = ST_PR_RD0;
        else if (idx_q == CW'(1)) state_d = iv_ok_q ? ST_PR_RD0 : ST_TP;
        else state_d = ST_IV_RD;
      end
      ST_PR_RD0: begin
        rd_addr = slot_of('0, head_q, count_q);
        state_d = ST_PR_LD;
      end
      ST_PR_LD:   state_d = ST_PR_RD;
      ST_PR_RD: begin
        rd_addr = slot_of(idx_q, head_q, count_q);
        state_d = ST_PR_CMP;
      end
      ST_PR_CMP: begin
        if (pair_ok) begin
          div_start = 1'b1;
          div_a     = {8'd0, rd_time_q - prev_time_q, 24'd0};
          div_b     = {32'd0, rd_bar_q - prev_bar_q};
          state_d   = ST_PR_DIV;
        end else if (idx_q == count_q - CW'(1)) begin
          state_d = ST_SP;
        end else begin
          state_d = ST_PR_RD;
        end
      end
      ST_PR_DIV: begin
        if (div_done) state_d = (idx_q == count_q - CW'(1)) ? ST_SP : ST_PR_RD;
      end
      ST_SP: begin
        if (n_q != '0) begin
          div_start = 1'b1;
          div_a     = sum_q;
          div_b     = 64'(n_q);
          state_d   = ST_SP_DIV;
        end else begin
          state_d = ST_TP;
        end
      end
      ST_SP_DIV:  if (div_done) state_d = ST_TP;
      ST_TP: begin
        if (!iv_ok_q || speed_q == '0 || interval_q == '0) state_d = ST_DONE;
        else state_d = ST_TP_MUL;
      end
      ST_TP_MUL:  if (mul_cnt_q == 5'd31) state_d = ST_TP_DIVS;
      ST_TP_DIVS: begin
        div_start = 1'b1;
        div_a     = TEMPO_NUM;
        div_b     = mul_acc_q;
        state_d   = ST_TP_DIV;
      end
      ST_TP_DIV:  if (div_done) state_d = ST_DONE;
      ST_T_CHK: begin
        if (count_q == '0 || speed_q == '0) state_d = ST_DONE;
        else state_d = ST_T_RD;
      end
      ST_T_RD:    state_d = ST_T_DS;
      ST_T_DS: begin
        div_start = 1'b1;
        div_a     = {8'd0, tick_dt, 24'd0};
        div_b     = {32'd0, speed_q};
        state_d   = ST_T_DIV;
      end
      ST_T_DIV: begin
        if (div_done) state_d = (lvalid_q && ev_int_q != '0) ? ST_T_Q1S : ST_T_UPD;
      end
      ST_T_Q1S: begin
        div_start = 1'b1;
        div_a     = {32'd0, pos_q};
        div_b     = {32'd0, ev_int_q};
        state_d   = ST_T_Q1;
      end
      ST_T_Q1:    if (div_done) state_d = ST_T_Q2S;
      ST_T_Q2S: begin
        div_start = 1'b1;
        div_a     = {32'd0, last_q};
        div_b     = {32'd0, ev_int_q};
        state_d   = ST_T_Q2;
      end
      ST_T_Q2:    if (div_done) state_d = ST_T_UPD;
      ST_T_UPD:   state_d = ST_DONE;
      ST_DONE:    if (go) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // beat history ring
  always_ff @(posedge clk_i) begin
    if (state_q == ST_B_CHK && !dup) begin
      bars_q[head_q]  <= in_q.beat_bar;
      times_q[head_q] <= in_q.time_ms;
    end
    rd_bar_q  <= bars_q[rd_addr];
    rd_time_q <= times_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      head_q      <= '0;
      speed_q     <= '0;
      interval_q  <= '0;
      iv_ok_q     <= 1'b0;
      last_q      <= '0;
      lvalid_q    <= 1'b0;
      ev_int_q    <= EVENT_INTERVAL_RST;
      lim_en_q    <= 1'b0;
      lim_bar_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_EVENT_INTERVAL: ev_int_q  <= cfg_data_i;
          CFG_LIMIT_ENABLE:   lim_en_q  <= cfg_data_i[0];
          CFG_LIMIT_BAR:      lim_bar_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_DONE && go) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_B_CHK: begin
          if (!dup) begin
            count_q <= cnt_new;
            head_q  <= head_next;
          end
        end
        ST_IV_CMP: begin
          if (prev_bar_q > rd_bar_q) begin
            interval_q <= prev_bar_q - rd_bar_q;
            iv_ok_q    <= 1'b1;
          end
        end
        ST_SP_DIV: if (div_done) speed_q <= sat32(div_quot);
        ST_T_UPD: begin
          last_q   <= pos_q;
          lvalid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          in_q  <= in_data_i;
          res_q <= '0;
          sum_q <= '0;
          n_q   <= '0;
        end
      end
      ST_IV_RD0:  idx_q <= count_q - CW'(1);
      ST_IV_LD:   prev_bar_q <= rd_bar_q;
      ST_IV_CMP: begin
        prev_bar_q <= rd_bar_q;
        idx_q      <= idx_q - CW'(1);
      end
      ST_PR_LD: begin
        prev_bar_q  <= rd_bar_q;
        prev_time_q <= rd_time_q;
        idx_q       <= CW'(1);
      end
      ST_PR_CMP: begin
        prev_bar_q  <= rd_bar_q;
        prev_time_q <= rd_time_q;
        if (!pair_ok) idx_q <= idx_q + CW'(1);
      end
      ST_PR_DIV: begin
        if (div_done) begin
          sum_q <= sum_q + div_quot;
          n_q   <= n_q + CW'(1);
          idx_q <= idx_q + CW'(1);
        end
      end
      ST_TP: begin
        mul_acc_q <= '0;
        mul_a_q   <= {32'd0, speed_q};
        mul_b_q   <= interval_q;
        mul_cnt_q <= '0;
      end
      ST_TP_MUL: begin
        if (mul_b_q[0]) mul_acc_q <= mul_acc_q + mul_a_q;
        mul_a_q   <= {mul_a_q[62:0], 1'b0};
        mul_b_q   <= {1'b0, mul_b_q[31:1]};
        mul_cnt_q <= mul_cnt_q + 5'd1;
      end
      ST_TP_DIV: begin
        if (div_done) begin
          res_q <= {res_q.event_valid, res_q.event_bar, sat32(div_quot), 1'b1,
                    res_q.speed_out};
        end
      end
      ST_T_DIV:   if (div_done) pos_q <= sat32({32'd0, rd_bar_q} + div_quot);
      ST_T_Q1:    if (div_done) fb_q <= pos_q - div_rem[31:0];
      ST_T_Q2: begin
        if (div_done && ev_hit) begin
          res_q <= {1'b1, fb_q, res_q.tempo, res_q.tempo_valid, res_q.speed_out};
        end
      end
      ST_DONE: begin
        if (go) begin
          out_q <= {res_q.event_valid, res_q.event_bar, res_q.tempo, res_q.tempo_valid,
                    speed_q};
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(BEAT_HISTORY))
    else $error("beat count beyond history depth");
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= HW'(BEAT_HISTORY - 1))
    else $error("ring head out of range");
  a_tempo_iv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.tempo_valid |-> iv_ok_q)
    else $error("tempo valid without interval");
  a_event_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.event_valid |-> lvalid_q)
    else $error("event without previous position");
`endif

endmodule

FILE: rtl/ttbc_div.sv
// Bit-serial restoring divider, 64 by 64 bits, one quotient bit per cycle.
// Depends on nothing; used by the tap-tempo beat clock controller.
module ttbc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [63:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quot_o,
  output logic [63:0] rem_o
);

  logic        busy_q;
  logic        done_q;
  logic [5:0]  cnt_q;
  logic [63:0] q_q, rem_q, div_q;
  logic [64:0] trial;
  logic        ge;

  assign trial = {rem_q, q_q[63]};
  assign ge    = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? 64'(trial - {1'b0, div_q}) : trial[63:0];
      q_q   <= {q_q[62:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;
  assign rem_o  = rem_q;

endmodule
